[design/lcmf_pkg.sv]
// Package for the LRU cache miss filter: register indexes, widths and shared types.
// Used by every module of the block but lcmf_ram. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lcmf_pkg;
  localparam int unsigned CntW = 48;
  localparam int unsigned AddrW = 64;
  localparam int unsigned LineW = 60;
  localparam int unsigned SizeW = 7;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [2:0] RegLineSize = 3'd0;
  localparam logic [2:0] RegSetCount = 3'd1;
  localparam logic [2:0] RegWays     = 3'd2;
  localparam logic [2:0] RegWarmup   = 3'd3;
  localparam logic [2:0] RegLimit    = 3'd4;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StClear = 6'b000010,
    StRead  = 6'b000100,
    StScan  = 6'b001000,
    StWrite = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + CntW'(1);
  endfunction
endpackage
`default_nettype wire

[design/lcmf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lcmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

[design/lru_cache_miss_filter_top.sv]
// Per line: a read state, a scan state that compares one way per step and chooses a victim,
// a write-back state and an output state that waits while out_stall_i is high; the single
// memory port walks the ways one at a time and so bounds the rate.
// After reset a clearing pass writes all MAX_SETS*MAX_WAYS entries and zeroes the valid bits in
// memory; no access is taken during it. Counters, state and flags reset asynchronously.
`timescale 1ns / 1ps
`default_nettype none
module lru_cache_miss_filter_top
  import lcmf_pkg::*;
#(
  parameter int unsigned MAX_SETS = 1024,
  parameter int unsigned MAX_WAYS = 16,
  parameter int unsigned MAX_ACCESS_BYTES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [AddrW-1:0]  access_address_i,
  input  wire logic [SizeW-1:0]  access_size_i,
  input  wire logic              inside_region_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [LineW-1:0]       line_index_o,
  output logic                   was_miss_o,
  output logic                   record_line_o,
  output logic [CntW-1:0]        total_misses_o,
  output logic                   access_end_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [CntW-1:0]   cfg_data_i
);
  localparam int unsigned Entries = MAX_SETS * MAX_WAYS;
  localparam int unsigned EntW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned MaxSb = $clog2(MAX_SETS);
  localparam int unsigned MemW = 1 + LineW + CntW;

  state_e state_q, state_d;
  logic [3:0] lsz_q, scl_q;
  logic [4:0] ways_q;
  logic [CntW-1:0] warm_q, limit_q;
  logic [CntW-1:0] stamp_q, accs_q, miss_q, recd_q;
  logic [EntW-1:0] clr_q;
  logic [LineW-1:0] line_q, last_q;
  logic region_q;
  logic [WayW:0] way_q;
  logic [WayW-1:0] vict_q;
  logic vict_inv_q;
  logic [CntW-1:0] vict_st_q;
  logic hit_q;
  logic [WayW-1:0] hit_way_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsz_q <= 4'd6; scl_q <= 4'd10; ways_q <= 5'd16;
      warm_q <= '0; limit_q <= CntW'(1000000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegLineSize: lsz_q <= cfg_data_i[3:0];
        RegSetCount: scl_q <= cfg_data_i[3:0];
        RegWays:     ways_q <= cfg_data_i[4:0];
        RegWarmup:   warm_q <= cfg_data_i;
        RegLimit:    limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [3:0] lb, sb;
  logic [5:0] nways;
  always_comb begin
    lb = (lsz_q < 4'd4) ? 4'd4 : (lsz_q > 4'd12) ? 4'd12 : lsz_q;
    sb = (32'(scl_q) > MaxSb) ? 4'(MaxSb) : scl_q;
    nways = (ways_q == 5'd0) ? 6'd1 :
            (32'(ways_q) > MAX_WAYS) ? 6'(MAX_WAYS) : {1'b0, ways_q};
  end

  logic [SetW-1:0] set_idx;
  logic [LineW-1:0] tag;
  always_comb begin
    set_idx = SetW'(line_q & ((LineW'(1) << sb) - LineW'(1)));
    tag = line_q >> sb;
  end

  // Memory entry: valid, tag, stamp.
  logic mem_we;
  logic [EntW-1:0] mem_addr;
  logic [MemW-1:0] mem_wd, mem_rd;
  lcmf_ram #(.Width(MemW), .Depth(Entries)) u_ram (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wd), .rdata_o(mem_rd)
  );
  logic rd_v;
  logic [LineW-1:0] rd_tag;
  logic [CntW-1:0] rd_st;
  assign {rd_v, rd_tag, rd_st} = mem_rd;

  logic [WayW-1:0] cur_way, wr_way;
  logic [CntW-1:0] stamp_n, miss_n;
  logic rec_n, do_miss;
  assign stamp_n = sat_inc(stamp_q);
  assign wr_way = hit_q ? hit_way_q : vict_q;
  assign do_miss = !hit_q;
  assign miss_n = sat_inc(miss_q);
  assign rec_n = region_q && (miss_n > warm_q) && (recd_q < limit_q);
  // way_q counts the read issued; the data in scan belongs to way_q-1.
  assign cur_way = WayW'(way_q - 1'b1);

  always_comb begin
    mem_we = 1'b0; mem_wd = '0;
    mem_addr = EntW'({set_idx, way_q[WayW-1:0]});
    if (MAX_WAYS == 1) mem_addr = EntW'(set_idx);
    unique case (state_q)
      StClear: begin mem_we = 1'b1; mem_addr = clr_q; end
      StWrite: begin
        mem_we = 1'b1;
        mem_addr = (MAX_WAYS == 1) ? EntW'(set_idx) : EntW'({set_idx, wr_way});
        mem_wd = {1'b1, tag, stamp_q};
      end
      default: ;
    endcase
  end

  logic [SizeW-1:0] sz;
  logic [AddrW:0] endsum;
  always_comb begin
    sz = (32'(access_size_i) > MAX_ACCESS_BYTES) ? SizeW'(MAX_ACCESS_BYTES) : access_size_i;
    endsum = {1'b0, access_address_i} + (AddrW+1)'(sz) - (AddrW+1)'(1);
  end

  logic scan_done;
  logic sel_hit, better;
  always_comb begin
    sel_hit = rd_v && rd_tag == tag;
    better = !vict_inv_q && (!rd_v || cur_way == '0 || rd_st < vict_st_q);
    scan_done = sel_hit || (32'(way_q) >= 32'(nways));
  end

  assign in_stall_o = (state_q != StIdle);
  logic out_v_q;
  assign out_valid_o = out_v_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (32'(clr_q) == Entries - 1) state_d = StIdle;
      StIdle: if (in_valid_i && sz != '0 && !endsum[AddrW]) state_d = StRead;
      StRead: state_d = StScan;
      StScan: if (scan_done) state_d = StWrite;
      StWrite: state_d = StOut;
      StOut: if (!out_stall_i) state_d = (line_q == last_q) ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0;
      stamp_q <= '0; accs_q <= '0; miss_q <= '0; recd_q <= '0;
      out_v_q <= 1'b0; way_q <= '0; hit_q <= 1'b0; vict_inv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: if (state_d == StRead) begin
          line_q <= LineW'(access_address_i >> lb);
          last_q <= LineW'(endsum[AddrW-1:0] >> lb);
          region_q <= inside_region_i;
        end
        StRead: begin
          way_q <= (WayW+1)'(1); hit_q <= 1'b0; vict_inv_q <= 1'b0;
          vict_q <= '0; accs_q <= sat_inc(accs_q); stamp_q <= stamp_n;
        end
        StScan: begin
          way_q <= way_q + 1'b1;
          if (sel_hit) begin hit_q <= 1'b1; hit_way_q <= cur_way; end
          else if (better || cur_way == '0) begin
            vict_q <= cur_way; vict_st_q <= rd_st; vict_inv_q <= !rd_v;
          end
        end
        StWrite: begin
          out_v_q <= 1'b1;
          line_index_o <= line_q;
          was_miss_o <= do_miss;
          access_end_o <= (line_q == last_q);
          record_line_o <= do_miss && rec_n;
          total_misses_o <= do_miss ? miss_n : miss_q;
          if (do_miss) begin
            miss_q <= miss_n;
            if (rec_n) recd_q <= sat_inc(recd_q);
          end
        end
        StOut: if (!out_stall_i) begin
          out_v_q <= 1'b0; line_q <= line_q + 1'b1; way_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/lcmf_checker.sv]
// Port-level checker for the miss filter, bound to the top level.
// Depends on lcmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcmf_props
  import lcmf_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic in_stall_o,
  input wire logic was_miss_o,
  input wire logic record_line_o,
  input wire logic [CntW-1:0] total_misses_o
);
  a_rec_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!record_line_o || was_miss_o)) else $error("record on hit");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_misses_o))
    else $error("stalled result changed");
endmodule
bind lru_cache_miss_filter_top lcmf_props u_chk (.*);
`default_nettype wire

[sim/lcmf_checker.sv]
// Checker for the LRU cache miss filter: watches the config, access and line channels,
// predicts every line transaction and compares it field by field. Depends on lcmf_pkg.
`timescale 1ns / 1ps
module lcmf_checker
  import lcmf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [AddrW-1:0] access_address_i,
  input  logic [SizeW-1:0] access_size_i,
  input  logic             inside_region_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [LineW-1:0] line_index_i,
  input  logic             was_miss_i,
  input  logic             record_line_i,
  input  logic [CntW-1:0]  total_misses_i,
  input  logic             access_end_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [CntW-1:0]  cfg_data_i,
  output int               fail_count_o,
  output int               lines_pending_o
);
  localparam int unsigned SetsMax = 1024;
  localparam int unsigned WaysMax = 16;
  localparam int unsigned Entries = SetsMax * WaysMax;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic             miss;
    logic             record;
    logic [CntW-1:0]  misses;
    logic             last;
  } line_result_t;

  line_result_t expected_lines[$];

  logic [63:0]     tag_mem[Entries];
  bit              valid_mem[Entries];
  logic [CntW-1:0] stamp_mem[Entries];
  logic [CntW-1:0] stamp_now, access_cnt, miss_cnt, record_cnt;
  logic [3:0]      line_log2, sets_log2;
  logic [4:0]      ways_cfg;
  logic [CntW-1:0] warmup, limit;

  assign lines_pending_o = expected_lines.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Returns 1 on a miss; updates the tag store the way the cache would.
  function automatic bit probe_line(input logic [63:0] line);
    int unsigned sb, nw, base, victim, idx;
    logic [63:0] tag;
    sb = (sets_log2 > 10) ? 10 : sets_log2;
    nw = (ways_cfg == 0) ? 1 : (ways_cfg > WaysMax) ? WaysMax : ways_cfg;
    base = int'(line & ((64'd1 << sb) - 1)) * WaysMax;
    tag = line >> sb;
    victim = base;
    stamp_now = sat_inc(stamp_now);
    for (int w = 0; w < nw; w++) begin
      idx = base + w;
      if (valid_mem[idx] && tag_mem[idx] == tag) begin
        stamp_mem[idx] = stamp_now;
        return 1'b0;
      end
    end
    for (int w = 0; w < nw; w++) begin
      idx = base + w;
      if (!valid_mem[idx]) begin
        victim = idx;
        break;
      end
      if (stamp_mem[idx] < stamp_mem[victim]) victim = idx;
    end
    valid_mem[victim] = 1'b1;
    tag_mem[victim] = tag;
    stamp_mem[victim] = stamp_now;
    return 1'b1;
  endfunction

  task automatic predict_access(input logic [63:0] addr, input logic [6:0] size,
                                input logic region);
    int unsigned lb;
    logic [63:0] nbytes, first_ln, last_ln, ln;
    line_result_t r;
    lb = (line_log2 < 4) ? 4 : (line_log2 > 12) ? 12 : line_log2;
    if (size == 0) return;
    nbytes = (size > 64) ? 64 : size;
    if (nbytes - 1 > ~addr) return;
    first_ln = addr >> lb;
    last_ln = (addr + nbytes - 1) >> lb;
    ln = first_ln;
    forever begin
      r = '0;
      access_cnt = sat_inc(access_cnt);
      r.miss = probe_line(ln);
      if (r.miss) begin
        miss_cnt = sat_inc(miss_cnt);
        if (region && miss_cnt > warmup && record_cnt < limit) begin
          r.record = 1'b1;
          record_cnt = sat_inc(record_cnt);
        end
      end
      r.line = ln[LineW-1:0];
      r.misses = miss_cnt;
      r.last = (ln == last_ln);
      expected_lines.push_back(r);
      if (ln == last_ln) break;
      ln++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        valid_mem[i] = 1'b0;
        tag_mem[i] = '0;
        stamp_mem[i] = '0;
      end
      stamp_now = '0;
      access_cnt = '0;
      miss_cnt = '0;
      record_cnt = '0;
      line_log2 = 4'd6;
      sets_log2 = 4'd10;
      ways_cfg = 5'd16;
      warmup = '0;
      limit = CntW'(1000000);
      fail_count_o = 0;
      expected_lines.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegLineSize: line_log2 = cfg_data_i[3:0];
          RegSetCount: sets_log2 = cfg_data_i[3:0];
          RegWays:     ways_cfg = cfg_data_i[4:0];
          RegWarmup:   warmup = cfg_data_i;
          RegLimit:    limit = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_lines.size() == 0) begin
          report("unexpected line_index", 64'(line_index_i), '0);
        end else begin
          want = expected_lines.pop_front();
          if (line_index_i !== want.line) report("line_index", line_index_i, want.line);
          if (was_miss_i !== want.miss) report("was_miss", was_miss_i, want.miss);
          if (record_line_i !== want.record)
            report("record_line", record_line_i, want.record);
          if (total_misses_i !== want.misses)
            report("total_misses", total_misses_i, want.misses);
          if (access_end_i !== want.last) report("access_end", access_end_i, want.last);
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_access(access_address_i, access_size_i, inside_region_i);
    end
  end
endmodule

[sim/tb.sv]
// Testbench top for the LRU cache miss filter: clock, reset, access and config stimulus,
// random stalls, verdict. Depends on lcmf_pkg, lcmf_checker and the block's RTL.
`timescale 1ns / 1ps
module tb;
  import lcmf_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 120;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [AddrW-1:0] access_address_i = '0;
  logic [SizeW-1:0] access_size_i = '0;
  logic             inside_region_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [LineW-1:0] line_index_o;
  logic             was_miss_o;
  logic             record_line_o;
  logic [CntW-1:0]  total_misses_o;
  logic             access_end_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i = '0;
  logic [CntW-1:0]  cfg_data_i = '0;

  int fail_count, lines_pending, cycle_count;
  int stall_left;
  bit calm;
  logic [63:0] hot_base;

  lru_cache_miss_filter_top DUT (.*);

  lcmf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .access_address_i,
    .access_size_i, .inside_region_i, .out_valid_i(out_valid_o), .out_stall_i,
    .line_index_i(line_index_o), .was_miss_i(was_miss_o), .record_line_i(record_line_o),
    .total_misses_i(total_misses_o), .access_end_i(access_end_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count),
    .lines_pending_o(lines_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: after each line transaction, hold off by a random stall, or not at all when calm is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) stall_left = calm ? 0 : $urandom_range(0, 16);
      else if (stall_left > 0) stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [CntW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [3:0] ls, input logic [3:0] sc, input logic [4:0] wy,
                              input logic [CntW-1:0] wm, input logic [CntW-1:0] lm);
    write_reg(RegLineSize, CntW'({$urandom, $urandom} & ~64'hF | 64'(ls)));
    write_reg(RegSetCount, CntW'(sc));
    write_reg(RegWays, {43'd0, wy});
    write_reg(RegWarmup, wm);
    write_reg(RegLimit, lm);
    write_reg(RegUnused, CntW'({$urandom, $urandom}));
  endtask

  task automatic send_access(input logic [63:0] addr, input logic [6:0] size,
                             input logic region);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    access_address_i <= addr;
    access_size_i <= size;
    inside_region_i <= region;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lines_pending != 0) @(posedge clk_i);
    // Accesses with no line result may still be in flight.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_accesses(input int count);
    logic [63:0] addr;
    logic [6:0]  size;
    int pick;
    hot_base = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) addr = hot_base + $urandom_range(0, 4095);
      else if (pick < 78) addr = hot_base + (64'($urandom_range(0, 7)) << 22)
                                 + $urandom_range(0, 255);
      else if (pick < 90) addr = {$urandom, $urandom};
      else addr = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100);
      pick = $urandom_range(0, 99);
      if (pick < 80) size = 7'($urandom_range(1, 64));
      else if (pick < 88) size = 7'd0;
      else size = 7'($urandom_range(65, 127));
      send_access(addr, size, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    stall_left = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_geometry(4'd6, 4'd10, 5'd16, '0, CntW'(1000000));
    send_access(64'd0, 7'd1, 1'b1);
    send_access(64'd0, 7'd1, 1'b1);
    send_access(64'd0, 7'd0, 1'b1);
    send_access(64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 1'b1);
    send_access(64'hFFFF_FFFF_FFFF_FFFF, 7'd2, 1'b1);
    send_access(64'hFFFF_FFFF_FFFF_FFC0, 7'd64, 1'b0);
    send_access(64'hFFFF_FFFF_FFFF_FFC1, 7'd64, 1'b1);
    send_access(64'h0000_0000_0000_003F, 7'd64, 1'b1);
    send_access(64'h0000_0000_0000_0020, 7'd127, 1'b0);
    send_access(64'h5555_5555_5555_5555, 7'd65, 1'b1);
    send_access(64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b0);
    send_access(64'h0000_0000_0000_0040, 7'd16, 1'b0);
    send_access(64'h0000_0000_0000_0040, 7'd16, 1'b1);
    drain();

    // One set, one way: every new line evicts the previous one.
    set_geometry(4'd4, 4'd0, 5'd1, '0, CntMax);
    send_access(64'h0000_0000_0000_0007, 7'd64, 1'b1);
    send_access(64'h0000_0000_0000_0000, 7'd16, 1'b1);
    send_access(64'h0000_0000_0000_0100, 7'd16, 1'b1);
    send_access(64'h0000_0000_0000_0000, 7'd16, 1'b1);
    send_access(64'hFFFF_FFFF_FFFF_FFF0, 7'd16, 1'b1);
    random_accesses(50);

    // Out-of-range settings are clamped; the tag store carries over.
    set_geometry(4'd15, 4'd15, 5'd31, CntMax, '0);
    random_accesses(50);
    set_geometry(4'd0, 4'd2, 5'd0, CntW'(10), CntW'(8));
    calm = 1'b1;
    random_accesses(60);
    calm = 1'b0;
    set_geometry(4'd4, 4'd2, 5'd4, CntW'(3), CntW'(40));
    random_accesses(70);
    set_geometry(4'd12, 4'd10, 5'd16, '0, CntMax);
    random_accesses(50);
    set_geometry(4'd5, 4'd4, 5'd3, '0, CntW'(100));
    random_accesses(70);
    set_geometry(4'd4, 4'd1, 5'd17, CntW'(1), CntW'(1000000));
    random_accesses(50);

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
